[sv/tinymt32_generator_unit_defines.svh]
// ----------------------------------------------------------------------------
// TinyMT32 generator assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef TINYMT32_GENERATOR_UNIT_DEFINES_SVH
`define TINYMT32_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define TMT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/tmt32_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TinyMT32 package
// Types, constants and small helpers shared by the generator files.
// ----------------------------------------------------------------------------
package tmt32_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumWords = 4;
  localparam int unsigned CountW  = 16;

  typedef logic [WordW-1:0]               word_t;
  typedef logic [NumWords-1:0][WordW-1:0] words_t;

  // opcodes of an input item
  typedef enum logic [1:0] {
    OP_RESEED  = 2'd0,
    OP_NEXT    = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_LOAD    = 2'd3
  } op_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAT1 = 2'd0,
    CFG_MAT2 = 2'd1,
    CFG_TMAT = 2'd2
  } cfg_idx_e;

  localparam word_t MAT1_RESET = 32'h8f70_11ee;
  localparam word_t MAT2_RESET = 32'hfc78_ff1f;
  localparam word_t TMAT_RESET = 32'h3793_fdff;
  localparam word_t INIT_MULT  = 32'h6c07_8965;
  localparam word_t LOW31_MASK = 32'h7fff_ffff;

  localparam int unsigned Sh0 = 1;
  localparam int unsigned Sh1 = 10;
  localparam int unsigned Sh8 = 8;

  // 'T','I','N','Y'
  localparam words_t GUARD_WORDS = {32'h0000_0059, 32'h0000_004e,
                                    32'h0000_0049, 32'h0000_0054};

  // mixing rounds and warm-up steps of a reseed
  localparam logic [2:0]        MIX_LAST     = 3'd7;
  localparam logic [CountW-1:0] RESEED_STEPS = 16'd8;

  // all 127 effective state bits zero
  function automatic logic state_zero(input words_t w);
    state_zero = ((w[0] & LOW31_MASK) == '0) && (w[1] == '0) &&
                 (w[2] == '0) && (w[3] == '0);
  endfunction

  // period guard
  function automatic words_t guard_words(input words_t w);
    guard_words = state_zero(w) ? GUARD_WORDS : w;
  endfunction

endpackage
`default_nettype wire

[sv/tmt32_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TinyMT32 request channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface tmt32_in_if
  import tmt32_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  word_t             data_word;
  logic [CountW-1:0] step_count;
  logic [1:0]        word_index;

  modport source (output valid, opcode, data_word, step_count, word_index,
                  input ready);
  modport sink   (input valid, opcode, data_word, step_count, word_index,
                  output ready);
endinterface
`default_nettype wire

[sv/tmt32_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TinyMT32 result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface tmt32_out_if
  import tmt32_pkg::*;
();
  logic  valid;
  logic  ready;
  word_t random_value;
  logic  value_valid;

  modport source (output valid, random_value, value_valid, input ready);
  modport sink   (input valid, random_value, value_valid, output ready);
endinterface
`default_nettype wire

[sv/tmt32_cfg_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TinyMT32 configuration channel
// Valid/ready register write channel: index and data.
// ----------------------------------------------------------------------------
interface tmt32_cfg_if
  import tmt32_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [1:0] index;
  word_t      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[sv/tinymt32_generator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TinyMT32 generator unit
// Sequenced TinyMT32 generator: reseed, next value, advance, load word.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      payload
//  in_i     in   valid/ready    opcode, data_word, step_count, word_index
//  out_o    out  valid/ready    random_value, value_valid
//  cfg_i    in   valid/ready    index (0 mat1, 1 mat2, 2 tmat), data
//
// Once an item is accepted the unit is busy until its result is registered:
// next value steps and tempers, advance by n steps n times, load word writes
// one word (word three then runs the guard), reseed runs seven mixing rounds,
// the guard and eight steps. The shared step unit does one state step a cycle;
// the mix multiplier is registered, so a round has a multiply and an add state.
// Reset loads 'T','I','N','Y' and the default mat1/mat2/tmat words.
// A result waits in the output register; the unit holds until it is taken.
// Configuration writes are accepted every cycle.
// ----------------------------------------------------------------------------
`include "tinymt32_generator_unit_defines.svh"

module tinymt32_generator_unit
  import tmt32_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tmt32_in_if.sink   in_i,
  tmt32_out_if.source out_o,
  tmt32_cfg_if.sink  cfg_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX_MUL,
    ST_MIX_ADD,
    ST_GUARD,
    ST_STEP,
    ST_TEMPER,
    ST_DONE
  } state_e;

  state_e            state_q, state_d;
  words_t            words_q, words_d;
  word_t             mat1_q, mat1_d;
  word_t             mat2_q, mat2_d;
  word_t             tmat_q, tmat_d;
  logic [2:0]        rnd_q, rnd_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  op_e               op_q, op_d;
  word_t             res_q, res_d;
  logic              gen_q, gen_d;
  logic              out_valid_q, out_valid_d;
  word_t             out_val_q, out_val_d;
  logic              out_gen_q, out_gen_d;

  logic   in_acc;
  word_t  mix_prev;
  word_t  mix_prod;
  words_t step_next;
  word_t  temper;
  logic   eff_zero;

  assign in_acc   = in_i.valid && in_i.ready;
  assign eff_zero = state_zero(words_q);

  // word used by the current mixing round
  assign mix_prev = words_q[rnd_q[1:0] - 2'd1];

  tmt32_mix_unit u_mix (
    .clk_i  (clk_i),
    .prev_i (mix_prev),
    .prod_o (mix_prod)
  );

  tmt32_step_unit u_step (
    .words_i  (words_q),
    .mat1_i   (mat1_q),
    .mat2_i   (mat2_q),
    .tmat_i   (tmat_q),
    .next_o   (step_next),
    .temper_o (temper)
  );

  // handshake outputs
  assign in_i.ready         = (state_q == ST_IDLE);
  assign cfg_i.ready        = 1'b1;
  assign out_o.valid        = out_valid_q;
  assign out_o.random_value = out_val_q;
  assign out_o.value_valid  = out_gen_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    words_d     = words_q;
    mat1_d      = mat1_q;
    mat2_d      = mat2_q;
    tmat_d      = tmat_q;
    rnd_d       = rnd_q;
    cnt_d       = cnt_q;
    op_d        = op_q;
    res_d       = res_q;
    gen_d       = gen_q;
    out_valid_d = out_valid_q;
    out_val_d   = out_val_q;
    out_gen_d   = out_gen_q;

    // configuration writes
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_MAT1: mat1_d = cfg_i.data;
        CFG_MAT2: mat2_d = cfg_i.data;
        CFG_TMAT: tmat_d = cfg_i.data;
        default:  ;
      endcase
    end

    // result taken
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_d = '0;
          gen_d = 1'b0;
          op_d  = op_e'(in_i.opcode);
          unique case (op_e'(in_i.opcode))
            OP_RESEED: begin
              words_d[0] = in_i.data_word;
              words_d[1] = mat1_q;
              words_d[2] = mat2_q;
              words_d[3] = tmat_q;
              rnd_d      = 3'd1;
              cnt_d      = RESEED_STEPS;
              state_d    = ST_MIX_MUL;
            end
            OP_NEXT: begin
              cnt_d   = CountW'(1);
              state_d = ST_STEP;
            end
            OP_ADVANCE: begin
              cnt_d   = in_i.step_count;
              state_d = (in_i.step_count == '0) ? ST_DONE : ST_STEP;
            end
            OP_LOAD: begin
              words_d[in_i.word_index] = in_i.data_word;
              cnt_d   = '0;
              state_d = (in_i.word_index == 2'd3) ? ST_GUARD : ST_DONE;
            end
            default: ;
          endcase
        end
      end
      ST_MIX_MUL: begin
        // product registers at this edge
        state_d = ST_MIX_ADD;
      end
      ST_MIX_ADD: begin
        words_d[rnd_q[1:0]] = words_q[rnd_q[1:0]] ^ (mix_prod + {29'd0, rnd_q});
        if (rnd_q == MIX_LAST) begin
          state_d = ST_GUARD;
        end else begin
          rnd_d   = rnd_q + 3'd1;
          state_d = ST_MIX_MUL;
        end
      end
      ST_GUARD: begin
        words_d = guard_words(words_q);
        state_d = (cnt_q == '0) ? ST_DONE : ST_STEP;
      end
      ST_STEP: begin
        words_d = step_next;
        cnt_d   = cnt_q - CountW'(1);
        if (cnt_q == CountW'(1)) begin
          state_d = (op_q == OP_NEXT) ? ST_TEMPER : ST_DONE;
        end
      end
      ST_TEMPER: begin
        res_d   = temper;
        gen_d   = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hand the result to the output register once it is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_val_d   = res_q;
          out_gen_d   = gen_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      words_q     <= GUARD_WORDS;
      mat1_q      <= MAT1_RESET;
      mat2_q      <= MAT2_RESET;
      tmat_q      <= TMAT_RESET;
      rnd_q       <= '0;
      cnt_q       <= '0;
      op_q        <= OP_RESEED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      words_q     <= words_d;
      mat1_q      <= mat1_d;
      mat2_q      <= mat2_d;
      tmat_q      <= tmat_d;
      rnd_q       <= rnd_d;
      cnt_q       <= cnt_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    gen_q     <= gen_d;
    out_val_q <= out_val_d;
    out_gen_q <= out_gen_d;
  end

  // checks
  `TMT_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_i.ready, "accepted item did not make unit busy")
  `TMT_ASSERT_NEXT(a_guard_nonzero, state_q == ST_GUARD, !eff_zero, "state zero after period guard")
  `TMT_ASSERT_NOW(a_step_count_live, state_q == ST_STEP, cnt_q != '0, "step state with zero count")
  `TMT_ASSERT_NOW(a_mix_round_range, (state_q == ST_MIX_MUL) || (state_q == ST_MIX_ADD), (rnd_q != 3'd0), "mix round out of range")

endmodule
`default_nettype wire

[sv/tmt32_mix_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TinyMT32 seed mixing multiplier
// Registered product INIT_MULT * (prev ^ (prev >> 30)), low 32 bits.
// ----------------------------------------------------------------------------
module tmt32_mix_unit
  import tmt32_pkg::*;
(
  input  wire logic  clk_i,
  input  wire word_t prev_i,
  output word_t      prod_o
);

  word_t fold;
  word_t prod_q;
  word_t prod_d;

  // fold top bits down, then multiply
  always_comb begin
    fold   = prev_i ^ (prev_i >> 30);
    prod_d = word_t'(fold * INIT_MULT);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

[sv/tmt32_step_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TinyMT32 state step and tempering
// Next state of one generator step, and the tempered word of the current state.
// ----------------------------------------------------------------------------
module tmt32_step_unit
  import tmt32_pkg::*;
(
  input  wire words_t words_i,
  input  wire word_t  mat1_i,
  input  wire word_t  mat2_i,
  input  wire word_t  tmat_i,
  output words_t      next_o,
  output word_t       temper_o
);

  word_t x0;
  word_t x;
  word_t y;
  word_t sum;

  // one state transition
  always_comb begin
    x0 = (words_i[0] & LOW31_MASK) ^ words_i[1] ^ words_i[2];
    x  = x0 ^ (x0 << Sh0);
    y  = words_i[3] ^ (words_i[3] >> Sh0) ^ x;
    next_o[0] = words_i[1];
    next_o[1] = words_i[2] ^ (y[0] ? mat1_i : '0);
    next_o[2] = x ^ (y << Sh1) ^ (y[0] ? mat2_i : '0);
    next_o[3] = y;
  end

  // tempering of the present state
  always_comb begin
    sum      = words_i[0] + (words_i[2] >> Sh8);
    temper_o = words_i[3] ^ sum ^ (sum[0] ? tmat_i : '0);
  end

endmodule
`default_nettype wire

[sim/tb_tinymt32_generator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TinyMT32 generator unit testbench
// Drives reseed, next, advance and load-word items through the request
// channel under random stalls, predicts every result with a local TinyMT32
// state copy and checks each result item in order. Configuration words are
// rewritten between drained phases: all zeros, all ones, random, reset values.
// ----------------------------------------------------------------------------
module tb_tinymt32_generator_unit;
  import tmt32_pkg::*;

  localparam int unsigned CycleLimit  = 3_000_000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned IdlePct     = 26;
  localparam int unsigned NumPhases   = 6;
  localparam logic [1:0]  CFG_UNUSED  = 2'd3;
  localparam logic [1:0]  LAST_WORD   = 2'd3;

  typedef struct packed {
    op_e               opcode;
    word_t             data_word;
    logic [CountW-1:0] step_count;
    logic [1:0]        word_index;
  } request_t;

  typedef struct packed {
    word_t random_value;
    logic  value_valid;
  } gen_value_t;

  logic clk_i;
  logic rst_ni;

  tmt32_in_if  in_if ();
  tmt32_out_if out_if ();
  tmt32_cfg_if cfg_if ();

  tinymt32_generator_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // predictor state
  word_t mt_words [4];
  word_t mt_mat1;
  word_t mt_mat2;
  word_t mt_tmat;

  request_t   request_q [$];
  gen_value_t value_q [$];

  logic        no_idle;
  int unsigned op_count [4];
  int unsigned checked_count;
  int unsigned error_count;
  int unsigned setting_count;
  int unsigned cycle_count;
  int unsigned big_left;

  // ---------------------------------------------------------------------------
  // TinyMT32 predictor
  // ---------------------------------------------------------------------------
  function automatic void mt_guard();
    if (mt_words[0][30:0] == '0 && mt_words[1] == '0 &&
        mt_words[2] == '0 && mt_words[3] == '0) begin
      for (int k = 0; k < 4; k++) mt_words[k] = GUARD_WORDS[k];
    end
  endfunction

  function automatic void mt_step();
    word_t x;
    word_t y;
    y = mt_words[3];
    x = (mt_words[0] & LOW31_MASK) ^ mt_words[1] ^ mt_words[2];
    x = x ^ (x << Sh0);
    y = y ^ (y >> Sh0) ^ x;
    mt_words[0] = mt_words[1];
    mt_words[1] = mt_words[2];
    mt_words[2] = x ^ (y << Sh1);
    mt_words[3] = y;
    if (y[0]) begin
      mt_words[1] = mt_words[1] ^ mt_mat1;
      mt_words[2] = mt_words[2] ^ mt_mat2;
    end
  endfunction

  function automatic word_t mt_temper();
    word_t sum;
    word_t res;
    sum = mt_words[0] + (mt_words[2] >> Sh8);
    res = mt_words[3] ^ sum;
    if (sum[0]) res = res ^ mt_tmat;
    return res;
  endfunction

  function automatic void mt_reseed(input word_t seed);
    word_t prev;
    mt_words[0] = seed;
    mt_words[1] = mt_mat1;
    mt_words[2] = mt_mat2;
    mt_words[3] = mt_tmat;
    // seven multiply-xor mixing rounds
    for (int unsigned i = 1; i < 8; i++) begin
      prev = mt_words[(i - 1) % 4];
      mt_words[i % 4] = mt_words[i % 4] ^
                        (word_t'(i) + INIT_MULT * (prev ^ (prev >> 30)));
    end
    mt_guard();
    for (int i = 0; i < 8; i++) mt_step();
  endfunction

  function automatic gen_value_t tinymt_predict(input request_t req);
    gen_value_t r;
    r = '0;
    case (req.opcode)
      OP_RESEED: mt_reseed(req.data_word);
      OP_NEXT: begin
        mt_step();
        r.random_value = mt_temper();
        r.value_valid  = 1'b1;
      end
      OP_ADVANCE: begin
        for (int unsigned n = 0; n < req.step_count; n++) mt_step();
      end
      OP_LOAD: begin
        mt_words[req.word_index] = req.data_word;
        if (req.word_index == LAST_WORD) mt_guard();
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: run exceeded %0d cycles, %0d results still pending",
               $time, CycleLimit, value_q.size());
      $display("tb_tinymt32_generator_unit failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver: front of request_q is what is on the channel
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    request_t   sent;
    gen_value_t want;
    logic       hold;
    if (!rst_ni) begin
      in_if.valid      <= 1'b0;
      in_if.opcode     <= OP_NEXT;
      in_if.data_word  <= '0;
      in_if.step_count <= '0;
      in_if.word_index <= '0;
    end else begin
      hold = in_if.valid && !in_if.ready;
      if (in_if.valid && in_if.ready) begin
        sent.opcode     = op_e'(in_if.opcode);
        sent.data_word  = in_if.data_word;
        sent.step_count = in_if.step_count;
        sent.word_index = in_if.word_index;
        want = tinymt_predict(sent);
        value_q.push_back(want);
        op_count[sent.opcode]++;
        void'(request_q.pop_front());
      end
      if (!hold) begin
        if (request_q.size() != 0 && (no_idle || $urandom_range(99) >= IdlePct)) begin
          in_if.valid      <= 1'b1;
          in_if.opcode     <= request_q[0].opcode;
          in_if.data_word  <= request_q[0].data_word;
          in_if.step_count <= request_q[0].step_count;
          in_if.word_index <= request_q[0].word_index;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result side backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= no_idle || ($urandom_range(99) >= IdlePct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : value_check
    gen_value_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (value_q.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual value %h valid %b",
                 $time, out_if.random_value, out_if.value_valid);
        error_count++;
      end else begin
        want = value_q.pop_front();
        checked_count++;
        if (out_if.random_value !== want.random_value) begin
          $display("%0t: random_value mismatch, expected %h actual %h",
                   $time, want.random_value, out_if.random_value);
          error_count++;
        end
        if (out_if.value_valid !== want.value_valid) begin
          $display("%0t: value_valid mismatch, expected %b actual %b",
                   $time, want.value_valid, out_if.value_valid);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_req(input op_e op, input word_t data,
                          input logic [CountW-1:0] cnt, input logic [1:0] idx);
    request_t r;
    r.opcode     = op;
    r.data_word  = data;
    r.step_count = cnt;
    r.word_index = idx;
    request_q.push_back(r);
  endtask

  // four loads, word zero first, so the guard sees the full state
  task automatic load_state(input word_t w0, input word_t w1,
                            input word_t w2, input word_t w3);
    push_req(OP_LOAD, w0, CountW'($urandom), 2'd0);
    push_req(OP_LOAD, w1, CountW'($urandom), 2'd1);
    push_req(OP_LOAD, w2, CountW'($urandom), 2'd2);
    push_req(OP_LOAD, w3, CountW'($urandom), LAST_WORD);
  endtask

  task automatic write_reg(input logic [1:0] idx, input word_t val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_MAT1: mt_mat1 = val;
      CFG_MAT2: mt_mat2 = val;
      CFG_TMAT: mt_tmat = val;
      default: ;
    endcase
  endtask

  task automatic write_all(input word_t m1, input word_t m2, input word_t tm);
    write_reg(CFG_MAT1, m1);
    write_reg(CFG_MAT2, m2);
    write_reg(CFG_TMAT, tm);
    setting_count++;
  endtask

  // wait until the channel is empty and every result has come back
  task automatic wait_drain();
    do @(posedge clk_i);
    while (request_q.size() != 0 || in_if.valid || value_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic push_directed();
    push_req(OP_NEXT, $urandom, CountW'($urandom), 2'($urandom));
    push_req(OP_RESEED, 32'h0000_0000, CountW'($urandom), 2'($urandom));
    push_req(OP_NEXT, $urandom, CountW'($urandom), 2'($urandom));
    push_req(OP_RESEED, 32'hffff_ffff, CountW'($urandom), 2'($urandom));
    push_req(OP_NEXT, $urandom, CountW'($urandom), 2'($urandom));
    // zero count leaves the state alone
    push_req(OP_ADVANCE, $urandom, 16'h0000, 2'($urandom));
    push_req(OP_NEXT, $urandom, CountW'($urandom), 2'($urandom));
    push_req(OP_ADVANCE, $urandom, 16'h0001, 2'($urandom));
    push_req(OP_ADVANCE, $urandom, 16'hffff, 2'($urandom));
    push_req(OP_NEXT, $urandom, CountW'($urandom), 2'($urandom));
    // only the top bit of word zero set still counts as a zero state
    load_state(32'h8000_0000, '0, '0, '0);
    push_req(OP_NEXT, $urandom, CountW'($urandom), 2'($urandom));
    load_state('0, '0, '0, '0);
    push_req(OP_NEXT, $urandom, CountW'($urandom), 2'($urandom));
    // zero the state through words zero to two: no guard, generator stuck at 0
    push_req(OP_LOAD, '0, CountW'($urandom), LAST_WORD);
    push_req(OP_LOAD, '0, CountW'($urandom), 2'd0);
    push_req(OP_LOAD, '0, CountW'($urandom), 2'd1);
    push_req(OP_LOAD, '0, CountW'($urandom), 2'd2);
    push_req(OP_NEXT, $urandom, CountW'($urandom), 2'($urandom));
    push_req(OP_RESEED, $urandom, 16'hffff, LAST_WORD);
  endtask

  // random mix, mostly next values, with load sequences and zero-state loads
  task automatic push_random(input int unsigned n_items);
    int unsigned        made;
    int unsigned        sel;
    logic [CountW-1:0]  cnt;
    made = 0;
    while (made < n_items) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        push_req(OP_RESEED, $urandom, CountW'($urandom), 2'($urandom));
        made += 1;
      end else if (sel < 60) begin
        push_req(OP_NEXT, $urandom, CountW'($urandom), 2'($urandom));
        made += 1;
      end else if (sel < 72) begin
        if (big_left != 0 && $urandom_range(199) == 0) begin
          cnt = 16'hffff;
          big_left--;
        end else if ($urandom_range(19) == 0) begin
          cnt = CountW'($urandom_range(4095, 256));
        end else begin
          cnt = CountW'($urandom_range(24));
        end
        push_req(OP_ADVANCE, $urandom, cnt, 2'($urandom));
        made += 1;
      end else if (sel < 82) begin
        load_state($urandom, $urandom, $urandom, $urandom);
        made += 4;
      end else if (sel < 86) begin
        load_state($urandom_range(1) ? 32'h8000_0000 : 32'h0, '0, '0, '0);
        made += 4;
      end else begin
        push_req(OP_LOAD, $urandom, CountW'($urandom), 2'($urandom));
        made += 1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase_items;
    rst_ni           = 1'b0;
    no_idle          = 1'b0;
    cycle_count      = 0;
    checked_count    = 0;
    error_count      = 0;
    setting_count    = 1;
    big_left         = 2;
    for (int k = 0; k < 4; k++) op_count[k] = 0;
    in_if.valid      = 1'b0;
    in_if.opcode     = OP_NEXT;
    in_if.data_word  = '0;
    in_if.step_count = '0;
    in_if.word_index = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_MAT1;
    cfg_if.data      = '0;

    // predictor starts from the reset state
    for (int k = 0; k < 4; k++) mt_words[k] = GUARD_WORDS[k];
    mt_mat1 = MAT1_RESET;
    mt_mat2 = MAT2_RESET;
    mt_tmat = TMAT_RESET;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed items under reset configuration
    @(negedge clk_i);
    push_directed();
    wait_drain();

    for (int ph = 1; ph <= NumPhases; ph++) begin
      phase_items = (ph <= 2) ? 150 : 300;
      case (ph)
        1: begin
          write_all('0, '0, '0);
          write_reg(CFG_UNUSED, $urandom);
        end
        2: write_all('1, '1, '1);
        6: write_all(MAT1_RESET, MAT2_RESET, TMAT_RESET);
        default: write_all($urandom, $urandom, $urandom);
      endcase
      no_idle = (ph == 3);
      @(negedge clk_i);
      push_req(OP_RESEED, $urandom, CountW'($urandom), 2'($urandom));
      push_random(phase_items);
      wait_drain();
    end
    no_idle = 1'b0;

    $display("run: %0d reseeds, %0d next values, %0d advances, %0d word loads",
             op_count[OP_RESEED], op_count[OP_NEXT], op_count[OP_ADVANCE],
             op_count[OP_LOAD]);
    $display("run: %0d results compared across %0d configuration settings",
             checked_count, setting_count);
    if (error_count == 0 && value_q.size() == 0) begin
      $display("tb_tinymt32_generator_unit passed");
    end else begin
      $display("tb_tinymt32_generator_unit failed");
    end
    $finish;
  end

endmodule
